### hdl/mlfr_pkg.sv
// shared constants, codes and types of the monochrome panel frame store controller
package mlfr_pkg;

  // panel geometry
  localparam int PAGE_COUNT   = 8;
  localparam int HALF_COLUMNS = 64;
  localparam int ROW_COLUMNS  = 2 * HALF_COLUMNS;
  localparam int STORE_BYTES  = PAGE_COUNT * ROW_COLUMNS;
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  // panel commands
  localparam logic [7:0] CMD_COLUMN   = 8'h40;
  localparam logic [7:0] CMD_PAGE     = 8'hb8;
  localparam logic [7:0] CMD_DISP_ON  = 8'h3f;
  localparam logic [7:0] CMD_DISP_OFF = 8'h3e;

  // item kinds
  typedef enum logic [2:0] {
    KIND_SET_PIXEL  = 3'd0,
    KIND_GET_PIXEL  = 3'd1,
    KIND_WRITE_BYTE = 3'd2,
    KIND_CLEAR      = 3'd3,
    KIND_REFRESH    = 3'd4,
    KIND_DISP_ON    = 3'd5,
    KIND_DISP_OFF   = 3'd6,
    KIND_TICK       = 3'd7
  } kind_t;

  // result kinds
  localparam logic [1:0] RES_BUS   = 2'd0;
  localparam logic [1:0] RES_PIXEL = 2'd1;
  localparam logic [1:0] RES_BUSY  = 2'd2;

  // register select
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // side selection codes
  localparam logic [1:0] SIDE_BOTH  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // sequence phases
  localparam logic [1:0] PH_COLUMN = 2'd0;
  localparam logic [1:0] PH_PAGE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

endpackage

### hdl/mono_lcd_framebuffer_refresh.sv
// top level: frame store controller for a two-half monochrome panel
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | kind, pos_x, pos_y, pixel_on, direct_byte
//  out_    | out | out_valid/out_stall| result_kind, reg_select, chip_left/right,
//          |     |                    | bus_byte, pixel_bit, last
//
// after reset a clearing pass writes zero to all 1024 store bytes, one a cycle;
// no item is taken during the pass.
// an item that needs the store waits for its registered read (set pixel reads
// then writes back, get pixel and refresh data ticks send the read byte); write
// byte sends column, page and data beats, one per cycle while out_stall is low,
// on the single output register; out_stall can hold any item back.
// a new item is taken while the output register drains in the same cycle.
module mono_lcd_framebuffer_refresh (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [6:0] in_pos_x,
  input  logic [5:0] in_pos_y,
  input  logic       in_pixel_on,
  input  logic [7:0] in_direct_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic       out_reg_select,
  output logic       out_chip_left,
  output logic       out_chip_right,
  output logic [7:0] out_bus_byte,
  output logic       out_pixel_bit,
  output logic       out_last
);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_READ = 5'b00100,
    ST_PAGE = 5'b01000,
    ST_DATA = 5'b10000
  } state_t;

  localparam int AW = mlfr_pkg::ADDR_W;

  // frame store
  logic [7:0]    mem [mlfr_pkg::STORE_BYTES];
  logic [7:0]    rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [1:0]    side_r, side_nxt;
  logic          seq_active_r, seq_active_nxt;
  logic          seq_refresh_r, seq_refresh_nxt;
  logic          seq_right_r, seq_right_nxt;
  logic [2:0]    seq_page_r, seq_page_nxt;
  logic [5:0]    seq_col_r, seq_col_nxt;
  logic [1:0]    seq_phase_r, seq_phase_nxt;

  // pending work held across a store read or a multi-beat item
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [2:0]    pend_bit_r, pend_bit_nxt;
  logic          pend_on_r, pend_on_nxt;
  logic          pend_set_r, pend_set_nxt;
  logic          pend_pixel_r, pend_pixel_nxt;
  logic          pend_cl_r, pend_cl_nxt;
  logic          pend_cr_r, pend_cr_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic [7:0]    pend_page_r, pend_page_nxt;
  logic [7:0]    pend_data_r, pend_data_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    o_kind_r;
  logic          o_rs_r, o_cl_r, o_cr_r, o_bit_r, o_last_r;
  logic [7:0]    o_byte_r;
  logic          load_out;
  logic [1:0]    o_kind;
  logic          o_rs, o_cl, o_cr, o_bit, o_last;
  logic [7:0]    o_byte;

  // item decode
  logic          out_free, accept;
  logic          side_cl, side_cr;
  logic [2:0]    pix_page;
  logic          pix_ok;
  logic [AW-1:0] pix_addr;
  logic          x_right;
  logic [6:0]    x_off;
  logic [5:0]    x_col;
  logic          byte_cl, byte_cr;
  logic          end_half, end_all, col_wrap, page_wrap;
  logic [AW-1:0] seq_addr;
  logic [7:0]    bit_mask;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // chip selects from the current side code; code 3 selects neither
  assign side_cl = (side_r == mlfr_pkg::SIDE_BOTH) || (side_r == mlfr_pkg::SIDE_LEFT);
  assign side_cr = (side_r == mlfr_pkg::SIDE_BOTH) || (side_r == mlfr_pkg::SIDE_RIGHT);

  // pixel address and range check
  assign pix_page = in_pos_y[5:3];
  assign pix_ok   = ({1'b0, pix_page} < 4'(mlfr_pkg::PAGE_COUNT)) &&
                    ({1'b0, in_pos_x} < 8'(mlfr_pkg::ROW_COLUMNS));
  assign pix_addr = AW'(int'(pix_page) * mlfr_pkg::ROW_COLUMNS + int'(in_pos_x));

  // write byte half selection
  assign x_right = {1'b0, in_pos_x} >= 8'(mlfr_pkg::HALF_COLUMNS);
  assign x_off   = in_pos_x - 7'(mlfr_pkg::HALF_COLUMNS);
  assign x_col   = x_right ? x_off[5:0] : in_pos_x[5:0];
  assign byte_cl = !x_right;
  assign byte_cr = x_right;

  // sequence end conditions and refresh address
  assign col_wrap  = ({1'b0, seq_col_r} + 7'd1) >= 7'(mlfr_pkg::HALF_COLUMNS);
  assign page_wrap = ({1'b0, seq_page_r} + 4'd1) >= 4'(mlfr_pkg::PAGE_COUNT);
  assign end_half  = col_wrap && page_wrap;
  assign end_all   = end_half && !(seq_refresh_r && !seq_right_r);
  assign seq_addr  = AW'(int'(seq_page_r) * mlfr_pkg::ROW_COLUMNS + int'(seq_col_r) +
                         (seq_right_r ? mlfr_pkg::HALF_COLUMNS : 0));

  assign bit_mask = 8'b1 << pend_bit_r;

  // next-state logic
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    side_nxt        = side_r;
    seq_active_nxt  = seq_active_r;
    seq_refresh_nxt = seq_refresh_r;
    seq_right_nxt   = seq_right_r;
    seq_page_nxt    = seq_page_r;
    seq_col_nxt     = seq_col_r;
    seq_phase_nxt   = seq_phase_r;
    pend_addr_nxt   = pend_addr_r;
    pend_bit_nxt    = pend_bit_r;
    pend_on_nxt     = pend_on_r;
    pend_set_nxt    = pend_set_r;
    pend_pixel_nxt  = pend_pixel_r;
    pend_cl_nxt     = pend_cl_r;
    pend_cr_nxt     = pend_cr_r;
    pend_last_nxt   = pend_last_r;
    pend_page_nxt   = pend_page_r;
    pend_data_nxt   = pend_data_r;
    mem_we    = 1'b0;
    mem_waddr = pend_addr_r;
    mem_wdata = pend_on_r ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    load_out  = 1'b0;
    o_kind    = mlfr_pkg::RES_BUS;
    o_rs      = mlfr_pkg::RS_CMD;
    o_cl      = 1'b0;
    o_cr      = 1'b0;
    o_byte    = 8'h00;
    o_bit     = 1'b0;
    o_last    = 1'b0;

    unique case (state_r)
      // clearing pass over the whole store
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = 8'h00;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(mlfr_pkg::STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // take one item
      ST_IDLE: begin
        if (accept) begin
          if (mlfr_pkg::kind_t'(in_kind) == mlfr_pkg::KIND_TICK) begin
            if (seq_active_r) begin
              load_out = 1'b1;
              o_cl     = side_cl;
              o_cr     = side_cr;
              if (seq_phase_r == mlfr_pkg::PH_PAGE) begin
                o_byte        = mlfr_pkg::CMD_PAGE + {5'b0, seq_page_r};
                seq_phase_nxt = mlfr_pkg::PH_DATA;
                seq_col_nxt   = '0;
              end else if (seq_phase_r != mlfr_pkg::PH_DATA) begin
                o_byte        = mlfr_pkg::CMD_COLUMN;
                seq_phase_nxt = mlfr_pkg::PH_PAGE;
              end else begin
                o_rs   = mlfr_pkg::RS_DATA;
                o_last = end_all;
                if (seq_refresh_r) begin
                  // data comes from the registered store read
                  load_out       = 1'b0;
                  mem_re         = 1'b1;
                  mem_raddr      = seq_addr;
                  pend_set_nxt   = 1'b0;
                  pend_pixel_nxt = 1'b0;
                  pend_cl_nxt    = side_cl;
                  pend_cr_nxt    = side_cr;
                  pend_last_nxt  = end_all;
                  state_nxt      = ST_READ;
                end
                // advance column, page and half
                if (!col_wrap) begin
                  seq_col_nxt = seq_col_r + 6'd1;
                end else begin
                  seq_col_nxt = '0;
                  if (!page_wrap) begin
                    seq_page_nxt  = seq_page_r + 3'd1;
                    seq_phase_nxt = mlfr_pkg::PH_PAGE;
                  end else begin
                    seq_page_nxt  = '0;
                    seq_phase_nxt = mlfr_pkg::PH_COLUMN;
                    if (end_all) begin
                      seq_active_nxt  = 1'b0;
                      seq_refresh_nxt = 1'b0;
                      seq_right_nxt   = 1'b0;
                    end else begin
                      seq_right_nxt = 1'b1;
                      side_nxt      = mlfr_pkg::SIDE_RIGHT;
                    end
                  end
                end
              end
            end
          end else if (seq_active_r) begin
            // refused while a sequence runs
            load_out = 1'b1;
            o_kind   = mlfr_pkg::RES_BUSY;
            o_last   = 1'b1;
          end else begin
            unique case (mlfr_pkg::kind_t'(in_kind))
              mlfr_pkg::KIND_SET_PIXEL: begin
                if (pix_ok) begin
                  mem_re        = 1'b1;
                  pend_addr_nxt = pix_addr;
                  pend_bit_nxt  = in_pos_y[2:0];
                  pend_on_nxt   = in_pixel_on;
                  pend_set_nxt  = 1'b1;
                  state_nxt     = ST_READ;
                end
              end
              mlfr_pkg::KIND_GET_PIXEL: begin
                if (pix_ok) begin
                  mem_re         = 1'b1;
                  pend_bit_nxt   = in_pos_y[2:0];
                  pend_set_nxt   = 1'b0;
                  pend_pixel_nxt = 1'b1;
                  state_nxt      = ST_READ;
                end else begin
                  load_out = 1'b1;
                  o_kind   = mlfr_pkg::RES_PIXEL;
                  o_last   = 1'b1;
                end
              end
              mlfr_pkg::KIND_WRITE_BYTE: begin
                load_out      = 1'b1;
                o_cl          = byte_cl;
                o_cr          = byte_cr;
                o_byte        = mlfr_pkg::CMD_COLUMN + {2'b00, x_col};
                side_nxt      = x_right ? mlfr_pkg::SIDE_RIGHT : mlfr_pkg::SIDE_LEFT;
                pend_cl_nxt   = byte_cl;
                pend_cr_nxt   = byte_cr;
                pend_page_nxt = mlfr_pkg::CMD_PAGE + {5'b0, pix_page};
                pend_data_nxt = in_direct_byte;
                state_nxt     = ST_PAGE;
              end
              mlfr_pkg::KIND_CLEAR, mlfr_pkg::KIND_REFRESH: begin
                seq_active_nxt  = 1'b1;
                seq_refresh_nxt = (mlfr_pkg::kind_t'(in_kind) == mlfr_pkg::KIND_REFRESH);
                seq_right_nxt   = 1'b0;
                seq_page_nxt    = '0;
                seq_col_nxt     = '0;
                seq_phase_nxt   = mlfr_pkg::PH_COLUMN;
                side_nxt        = (mlfr_pkg::kind_t'(in_kind) == mlfr_pkg::KIND_REFRESH) ?
                                  mlfr_pkg::SIDE_LEFT : mlfr_pkg::SIDE_BOTH;
              end
              mlfr_pkg::KIND_DISP_ON: begin
                load_out = 1'b1;
                o_cl     = side_cl;
                o_cr     = side_cr;
                o_byte   = mlfr_pkg::CMD_DISP_ON;
                o_last   = 1'b1;
              end
              mlfr_pkg::KIND_DISP_OFF: begin
                load_out = 1'b1;
                o_cl     = side_cl;
                o_cr     = side_cr;
                o_byte   = mlfr_pkg::CMD_DISP_OFF;
                o_last   = 1'b1;
              end
              mlfr_pkg::KIND_TICK: begin
                // handled above
              end
            endcase
          end
        end
      end

      // store data has arrived: write back or send it
      ST_READ: begin
        if (pend_set_r) begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (pend_pixel_r) begin
            o_kind = mlfr_pkg::RES_PIXEL;
            o_bit  = rd_data_r[pend_bit_r];
            o_last = 1'b1;
          end else begin
            o_rs   = mlfr_pkg::RS_DATA;
            o_cl   = pend_cl_r;
            o_cr   = pend_cr_r;
            o_byte = rd_data_r;
            o_last = pend_last_r;
          end
        end
      end

      // write byte: page command beat
      ST_PAGE: begin
        if (out_free) begin
          load_out  = 1'b1;
          o_cl      = pend_cl_r;
          o_cr      = pend_cr_r;
          o_byte    = pend_page_r;
          state_nxt = ST_DATA;
        end
      end

      // write byte: data beat
      ST_DATA: begin
        if (out_free) begin
          load_out  = 1'b1;
          o_rs      = mlfr_pkg::RS_DATA;
          o_cl      = pend_cl_r;
          o_cr      = pend_cr_r;
          o_byte    = pend_data_r;
          o_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // output register occupancy
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // store memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      clr_addr_r    <= '0;
      side_r        <= mlfr_pkg::SIDE_BOTH;
      seq_active_r  <= 1'b0;
      seq_refresh_r <= 1'b0;
      seq_right_r   <= 1'b0;
      seq_page_r    <= '0;
      seq_col_r     <= '0;
      seq_phase_r   <= mlfr_pkg::PH_COLUMN;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      side_r        <= side_nxt;
      seq_active_r  <= seq_active_nxt;
      seq_refresh_r <= seq_refresh_nxt;
      seq_right_r   <= seq_right_nxt;
      seq_page_r    <= seq_page_nxt;
      seq_col_r     <= seq_col_nxt;
      seq_phase_r   <= seq_phase_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_bit_r   <= pend_bit_nxt;
    pend_on_r    <= pend_on_nxt;
    pend_set_r   <= pend_set_nxt;
    pend_pixel_r <= pend_pixel_nxt;
    pend_cl_r    <= pend_cl_nxt;
    pend_cr_r    <= pend_cr_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_page_r  <= pend_page_nxt;
    pend_data_r  <= pend_data_nxt;
    if (load_out) begin
      o_kind_r <= o_kind;
      o_rs_r   <= o_rs;
      o_cl_r   <= o_cl;
      o_cr_r   <= o_cr;
      o_byte_r <= o_byte;
      o_bit_r  <= o_bit;
      o_last_r <= o_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = o_kind_r;
  assign out_reg_select  = o_rs_r;
  assign out_chip_left   = o_cl_r;
  assign out_chip_right  = o_cr_r;
  assign out_bus_byte    = o_byte_r;
  assign out_pixel_bit   = o_bit_r;
  assign out_last        = o_last_r;

  // no result leaves before the clearing pass ends
  a_no_out_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !out_valid_r)
    else $error("result beat during store clearing");

  // store writes only come from clearing or pixel write-back
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_INIT) || (state_r == ST_READ && pend_set_r)))
    else $error("unexpected store write");

  // sequence position stays inside the panel
  a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_active_r |-> (({1'b0, seq_page_r} < 4'(mlfr_pkg::PAGE_COUNT)) &&
                      ({1'b0, seq_col_r} < 7'(mlfr_pkg::HALF_COLUMNS))))
    else $error("sequence position out of range");

  // page command beat is followed by the data beat state with a beat held
  a_byte_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAGE && out_free) |=> (state_r == ST_DATA && out_valid_r))
    else $error("write byte beats out of order");

  // the state after a pixel write-back is idle
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && pend_set_r) |=> (state_r == ST_IDLE))
    else $error("pixel write-back stuck");

endmodule

### test/panel_result_checker.sv
// checker for the panel frame store controller: predicts result beats and compares them
`timescale 1ns / 100ps
module panel_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_kind,
  input  logic [6:0] in_pos_x,
  input  logic [5:0] in_pos_y,
  input  logic       in_pixel_on,
  input  logic [7:0] in_direct_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_result_kind,
  input  logic       out_reg_select,
  input  logic       out_chip_left,
  input  logic       out_chip_right,
  input  logic [7:0] out_bus_byte,
  input  logic       out_pixel_bit,
  input  logic       out_last,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [1:0] kind_code;
    logic       reg_sel;
    logic       cs_left;
    logic       cs_right;
    logic [7:0] data;
    logic       pixel;
    logic       fin;
  } panel_beat_t;

  // mirror of the frame store and the transfer sequencer
  logic [7:0]  image [mlfr_pkg::STORE_BYTES];
  logic [1:0]  side;
  logic        seq_on;
  logic        seq_refresh;
  logic        seq_right;
  logic [2:0]  seq_pg;
  logic [5:0]  seq_col;
  logic [1:0]  seq_ph;
  panel_beat_t panel_beats_due [$];

  // bus write beat with chip selects taken from the current side selection
  function automatic panel_beat_t bus_beat(logic rs, logic [7:0] data, logic fin);
    panel_beat_t b;
    b          = '0;
    b.kind_code = mlfr_pkg::RES_BUS;
    b.reg_sel  = rs;
    b.cs_left  = (side == mlfr_pkg::SIDE_BOTH) || (side == mlfr_pkg::SIDE_LEFT);
    b.cs_right = (side == mlfr_pkg::SIDE_BOTH) || (side == mlfr_pkg::SIDE_RIGHT);
    b.data     = data;
    b.fin      = fin;
    return b;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // works out the result beats of one accepted item and updates the mirror
  task automatic predict_panel_item(mlfr_pkg::kind_t k, logic [6:0] x, logic [5:0] y,
                                    logic on, logic [7:0] db);
    panel_beat_t b;
    int          idx;
    logic [6:0]  col;
    logic [7:0]  data;
    logic        half_done;
    logic        all_done;
    idx = -1;
    if (int'(y[5:3]) < mlfr_pkg::PAGE_COUNT && int'(x) < mlfr_pkg::ROW_COLUMNS)
      idx = int'(y[5:3]) * mlfr_pkg::ROW_COLUMNS + int'(x);
    b     = '0;
    b.fin = 1'b1;
    if (k == mlfr_pkg::KIND_TICK) begin
      // a tick with no sequence running does nothing
      if (seq_on) begin
        case (seq_ph)
          mlfr_pkg::PH_PAGE: begin
            panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD,
                                               mlfr_pkg::CMD_PAGE + 8'(seq_pg), 1'b0));
            seq_ph  = mlfr_pkg::PH_DATA;
            seq_col = '0;
          end
          mlfr_pkg::PH_DATA: begin
            data = '0;
            if (seq_refresh) begin
              idx = int'(seq_pg) * mlfr_pkg::ROW_COLUMNS + int'(seq_col) +
                    (seq_right ? mlfr_pkg::HALF_COLUMNS : 0);
              if (idx < mlfr_pkg::STORE_BYTES) data = image[idx];
            end
            half_done = (int'(seq_col) == mlfr_pkg::HALF_COLUMNS - 1) &&
                        (int'(seq_pg) == mlfr_pkg::PAGE_COUNT - 1);
            all_done  = half_done && !(seq_refresh && !seq_right);
            panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_DATA, data, all_done));
            if (int'(seq_col) < mlfr_pkg::HALF_COLUMNS - 1) begin
              seq_col = seq_col + 6'd1;
            end else begin
              seq_col = '0;
              if (int'(seq_pg) < mlfr_pkg::PAGE_COUNT - 1) begin
                seq_pg = seq_pg + 3'd1;
                seq_ph = mlfr_pkg::PH_PAGE;
              end else begin
                seq_pg = '0;
                seq_ph = mlfr_pkg::PH_COLUMN;
                // a refresh on the left half moves on to the right half, otherwise the sequence ends
                if (all_done) begin
                  seq_on      = 1'b0;
                  seq_refresh = 1'b0;
                  seq_right   = 1'b0;
                end else begin
                  seq_right = 1'b1;
                  side      = mlfr_pkg::SIDE_RIGHT;
                end
              end
            end
          end
          // column command phase; the unused phase code behaves the same
          default: begin
            panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD, mlfr_pkg::CMD_COLUMN,
                                               1'b0));
            seq_ph = mlfr_pkg::PH_PAGE;
          end
        endcase
      end
    end else if (seq_on) begin
      // refused while a sequence runs
      b.kind_code = mlfr_pkg::RES_BUSY;
      panel_beats_due.push_back(b);
    end else begin
      case (k)
        mlfr_pkg::KIND_SET_PIXEL: begin
          if (idx >= 0) image[idx][y[2:0]] = on;
        end
        mlfr_pkg::KIND_GET_PIXEL: begin
          b.kind_code = mlfr_pkg::RES_PIXEL;
          if (idx >= 0) b.pixel = image[idx][y[2:0]];
          panel_beats_due.push_back(b);
        end
        mlfr_pkg::KIND_WRITE_BYTE: begin
          if (int'(x) < mlfr_pkg::HALF_COLUMNS) begin
            side = mlfr_pkg::SIDE_LEFT;
            col  = x;
          end else begin
            side = mlfr_pkg::SIDE_RIGHT;
            col  = x - 7'(mlfr_pkg::HALF_COLUMNS);
          end
          panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD,
                                             mlfr_pkg::CMD_COLUMN + 8'(col[5:0]), 1'b0));
          panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD,
                                             mlfr_pkg::CMD_PAGE + 8'(y[5:3]), 1'b0));
          panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_DATA, db, 1'b1));
        end
        mlfr_pkg::KIND_CLEAR, mlfr_pkg::KIND_REFRESH: begin
          seq_on      = 1'b1;
          seq_refresh = (k == mlfr_pkg::KIND_REFRESH);
          seq_right   = 1'b0;
          seq_pg      = '0;
          seq_col     = '0;
          seq_ph      = mlfr_pkg::PH_COLUMN;
          side        = (k == mlfr_pkg::KIND_REFRESH) ? mlfr_pkg::SIDE_LEFT :
                                                        mlfr_pkg::SIDE_BOTH;
        end
        mlfr_pkg::KIND_DISP_ON:
          panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD, mlfr_pkg::CMD_DISP_ON, 1'b1));
        mlfr_pkg::KIND_DISP_OFF:
          panel_beats_due.push_back(bus_beat(mlfr_pkg::RS_CMD, mlfr_pkg::CMD_DISP_OFF, 1'b1));
        default: ;
      endcase
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin : watch
    panel_beat_t want;
    if (!rst_n) begin
      foreach (image[i]) image[i] = '0;
      side        = mlfr_pkg::SIDE_BOTH;
      seq_on      = 1'b0;
      seq_refresh = 1'b0;
      seq_right   = 1'b0;
      seq_pg      = '0;
      seq_col     = '0;
      seq_ph      = mlfr_pkg::PH_COLUMN;
      fail_count  = 0;
      panel_beats_due.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (panel_beats_due.size() == 0) begin
          $error("result beat with nothing expected, result_kind %0h", out_result_kind);
          fail_count++;
        end else begin
          want = panel_beats_due.pop_front();
          check_field("result_kind", 8'(want.kind_code), 8'(out_result_kind));
          check_field("reg_select", 8'(want.reg_sel), 8'(out_reg_select));
          check_field("chip_left", 8'(want.cs_left), 8'(out_chip_left));
          check_field("chip_right", 8'(want.cs_right), 8'(out_chip_right));
          check_field("bus_byte", want.data, out_bus_byte);
          check_field("pixel_bit", 8'(want.pixel), 8'(out_pixel_bit));
          check_field("last", 8'(want.fin), 8'(out_last));
        end
      end
      // item beat into the predictor
      if (in_valid && !in_stall)
        predict_panel_item(mlfr_pkg::kind_t'(in_kind), in_pos_x, in_pos_y, in_pixel_on,
                           in_direct_byte);
    end
    pending = panel_beats_due.size();
  end

endmodule

### test/tb_top.sv
// testbench top: clock, reset, item stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module tb_top;

  localparam int RANDOM_ITEMS = 190;
  localparam int SEQ_TICKS    = 45;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_START   = 1100;
  localparam int HOLD_CYCLES  = 400;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_kind;
  logic [6:0] in_pos_x;
  logic [5:0] in_pos_y;
  logic       in_pixel_on;
  logic [7:0] in_direct_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_result_kind;
  logic       out_reg_select;
  logic       out_chip_left;
  logic       out_chip_right;
  logic [7:0] out_bus_byte;
  logic       out_pixel_bit;
  logic       out_last;
  int         fail_count;
  int         pending;
  int         burst_left;

  mono_lcd_framebuffer_refresh dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_direct_byte (in_direct_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_reg_select (out_reg_select),
    .out_chip_left  (out_chip_left),
    .out_chip_right (out_chip_right),
    .out_bus_byte   (out_bus_byte),
    .out_pixel_bit  (out_pixel_bit),
    .out_last       (out_last)
  );

  panel_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_on    (in_pixel_on),
    .in_direct_byte (in_direct_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_reg_select (out_reg_select),
    .out_chip_left  (out_chip_left),
    .out_chip_right (out_chip_right),
    .out_bus_byte   (out_bus_byte),
    .out_pixel_bit  (out_pixel_bit),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // columns near the half boundary and rows near the first page edge come up often
  function automatic logic [6:0] pick_x();
    if ($urandom_range(0, 1) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(60, 67));
  endfunction

  function automatic logic [5:0] pick_y();
    if ($urandom_range(0, 1) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 9));
  endfunction

  // one item beat; gaps fall between bursts of random length
  task automatic offer(mlfr_pkg::kind_t k, logic [6:0] x, logic [5:0] y, logic on,
                       logic [7:0] db);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_on    <= on;
    in_direct_byte <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random(mlfr_pkg::kind_t k);
    offer(k, pick_x(), pick_y(), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // start a clear or refresh and give it some ticks, with refused items mixed in
  task automatic run_sequence(mlfr_pkg::kind_t start, int ticks);
    int ticks_left;
    offer_random(start);
    ticks_left = ticks;
    while (ticks_left > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        offer_random(mlfr_pkg::kind_t'($urandom_range(0, 6)));
      end else begin
        offer_random(mlfr_pkg::KIND_TICK);
        ticks_left--;
      end
    end
  endtask

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[mono_lcd_framebuffer_refresh] ERROR");
    $finish;
  end

  // receiver: alternating free and stall runs, plus one long hold-off
  initial begin : receiver
    int   cyc;
    int   run_len;
    logic run_stall;
    logic held;
    out_stall = 1'b0;
    cyc       = 0;
    run_len   = 0;
    run_stall = 1'b1;
    held      = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!held && cyc >= HOLD_START) begin
        held      = 1'b1;
        run_stall = 1'b1;
        run_len   = HOLD_CYCLES;
      end else if (run_len == 0) begin
        run_stall = !run_stall;
        if (run_stall)
          run_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        else
          run_len = $urandom_range(1, 24);
      end
      if (run_len != 0) begin
        out_stall <= run_stall;
        run_len--;
        @(negedge clk);
        cyc++;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int done_items;
    int roll;
    int waited;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = mlfr_pkg::KIND_SET_PIXEL;
    in_pos_x       = '0;
    in_pos_y       = '0;
    in_pixel_on    = 1'b0;
    in_direct_byte = '0;
    burst_left     = 0;
    done_items     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, page and half edges, every kind but clear and refresh
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd0, 6'd0, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_SET_PIXEL, 7'd0, 6'd0, 1'b1, 8'h00);
    offer(mlfr_pkg::KIND_SET_PIXEL, 7'd127, 6'd63, 1'b1, 8'hff);
    offer(mlfr_pkg::KIND_SET_PIXEL, 7'd64, 6'd7, 1'b1, 8'h00);
    offer(mlfr_pkg::KIND_SET_PIXEL, 7'd63, 6'd8, 1'b1, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd0, 6'd0, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd127, 6'd63, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd64, 6'd7, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd63, 6'd8, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd1, 6'd0, 1'b1, 8'hff);
    offer(mlfr_pkg::KIND_SET_PIXEL, 7'd127, 6'd63, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_GET_PIXEL, 7'd127, 6'd63, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_WRITE_BYTE, 7'd0, 6'd0, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_WRITE_BYTE, 7'd127, 6'd63, 1'b1, 8'hff);
    offer(mlfr_pkg::KIND_WRITE_BYTE, 7'd63, 6'd8, 1'b0, 8'ha5);
    offer(mlfr_pkg::KIND_WRITE_BYTE, 7'd64, 6'd56, 1'b0, 8'h5a);
    offer(mlfr_pkg::KIND_DISP_ON, 7'd0, 6'd0, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_DISP_OFF, 7'd0, 6'd0, 1'b0, 8'h00);
    // idle tick gives nothing
    offer(mlfr_pkg::KIND_TICK, 7'd5, 6'd5, 1'b1, 8'h11);
    offer(mlfr_pkg::KIND_DISP_ON, 7'd0, 6'd0, 1'b0, 8'h00);
    offer(mlfr_pkg::KIND_DISP_OFF, 7'd0, 6'd0, 1'b0, 8'h00);

    // random: mostly pixel traffic with idle ticks mixed in
    while (done_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        offer_random(mlfr_pkg::KIND_TICK);
      end else begin
        if (roll < 38)      offer_random(mlfr_pkg::KIND_SET_PIXEL);
        else if (roll < 63) offer_random(mlfr_pkg::KIND_GET_PIXEL);
        else if (roll < 80) offer_random(mlfr_pkg::KIND_WRITE_BYTE);
        else if (roll < 90) offer_random(mlfr_pkg::KIND_DISP_ON);
        else                offer_random(mlfr_pkg::KIND_DISP_OFF);
        done_items++;
      end
    end

    // refresh of the drawn image: command beats, store reads and refused items
    run_sequence(mlfr_pkg::KIND_REFRESH, SEQ_TICKS);
    in_valid <= 1'b0;

    // drain outstanding beats, then a short settle
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (16) @(negedge clk);
    if (pending != 0) $error("%0d result beats never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("[mono_lcd_framebuffer_refresh] OK");
    else
      $display("[mono_lcd_framebuffer_refresh] ERROR");
    $finish;
  end

endmodule
